### hdl/ddo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ddo_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int ANGLE_BITS   = 32;
   localparam int CORD_IDX_W   = $clog2(CORDIC_STEPS);
   localparam int DIV_BITS     = 64;
   localparam int DIV_CNT_W    = $clog2(DIV_BITS);

   localparam logic [31:0] ANGLE_MASK =
      32'(~((64'd1 << (32 - ANGLE_BITS)) - 64'd1));
   localparam logic signed [33:0] CORDIC_K       = 34'sd652032874;
   localparam logic signed [34:0] TWO_OVER_PI    = 35'sd683565276;
   localparam logic [63:0]        ARC_LIMIT      = 64'd8589934592;

   // configuration register indexes
   localparam logic [2:0] CSR_METHOD    = 3'd0;
   localparam logic [2:0] CSR_LEFT_POL  = 3'd1;
   localparam logic [2:0] CSR_RIGHT_POL = 3'd2;
   localparam logic [2:0] CSR_TRAVEL    = 3'd3;
   localparam logic [2:0] CSR_INV_BASE  = 3'd4;
   localparam logic [2:0] CSR_GYRO_GAIN = 3'd5;
   localparam logic [2:0] CSR_GYRO_LIM  = 3'd6;

   localparam logic [1:0] METHOD_MID      = 2'd0;
   localparam logic [1:0] METHOD_ARC      = 2'd1;
   localparam logic [1:0] METHOD_GYRO     = 2'd2;
   // spare code, behaves as gyro assisted
   localparam logic [1:0] METHOD_GYRO_ALT = 2'd3;

   // cordic angle sources
   localparam logic [1:0] ANG_YAW     = 2'd0;
   localparam logic [1:0] ANG_YAW_DTO = 2'd1;
   localparam logic [1:0] ANG_MID     = 2'd2;

   typedef struct packed {
      logic       load;
      logic       mul1;
      logic       mul2;
      logic       mul3;
      logic       sel;
      logic       cord_start;
      logic [1:0] cord_ang;
      logic       cord_step;
      logic       save0;
      logic       save1;
      logic       num;
      logic       axis;
      logic       div_start;
      logic       arc_mul;
      logic       mid_mul;
      logic       update;
   } cmd_type;

   typedef struct packed {
      logic cord_last;
      logic div_done;
      logic use_arc;
      logic out_free;
   } sts_type;

   function automatic logic [31:0] atan_bam(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;
         5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

### hdl/differential_drive_odometry.sv
`timescale 1ns / 1ps
`default_nettype none
// Differential-drive odometry: each accepted req transaction is one sample period (absolute
// left/right encoder counts and a gyro yaw-rate sample); one rsp transaction returns the
// updated x/y position and travelled distance (signed Q16.16 metres) and the heading
// (32-bit binary angle). One item is processed at a time. Midpoint and gyro-assisted
// methods run the multiply stages, then one CORDIC run of CORDIC_STEPS iterations. The
// exact-arc method runs two CORDIC runs and two 64-bit bit-serial divisions on the
// shared divider; with zero heading change it takes the midpoint path instead. The next
// transaction is accepted as soon as the previous one has updated its state, while its
// result may still wait in the output register. Configuration is written through
// csr_write / csr_index / csr_data, by the user only while idle; the block does not check.
module differential_drive_odometry (
   input  wire logic               clock,
   input  wire logic               reset,
   // input channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [31:0] req_left_count,
   input  wire logic signed [31:0] req_right_count,
   input  wire logic signed [15:0] req_gyro_rate,
   // result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_x_position,
   output logic signed [31:0]      rsp_y_position,
   output logic signed [31:0]      rsp_heading,
   output logic signed [31:0]      rsp_travelled,
   // configuration write port
   input  wire logic               csr_write,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_data
);

   // command and status between sequencer and datapath
   ddo_pkg::cmd_type cmd;
   ddo_pkg::sts_type sts;

   // sequencer: steps through multiply, cordic and divide phases
   ddo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: registers, state, cordic, divider and output register
   ddo_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_left_count  (req_left_count),
      .req_right_count (req_right_count),
      .req_gyro_rate   (req_gyro_rate),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_x_position  (rsp_x_position),
      .rsp_y_position  (rsp_y_position),
      .rsp_heading     (rsp_heading),
      .rsp_travelled   (rsp_travelled)
   );

endmodule
`default_nettype wire

### hdl/ddo_div.sv
`timescale 1ns / 1ps
`default_nettype none
module ddo_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] num,
   input  wire logic [31:0] den,
   output logic             done,
   output logic [63:0]      quo
);

   logic [31:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] den_ff;
   logic [ddo_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [32:0] trial;

   // restoring division, one quotient bit a cycle
   always_comb begin
      trial   = {rem_ff, quo_ff[63]};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 32'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ddo_pkg::DIV_CNT_W'(ddo_pkg::DIV_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (start) den_ff <= den;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule
`default_nettype wire

### hdl/ddo_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module ddo_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ddo_pkg::cmd_type   cmd,
   output ddo_pkg::sts_type        sts,
   input  wire logic               csr_write,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_data,
   input  wire logic signed [31:0] req_left_count,
   input  wire logic signed [31:0] req_right_count,
   input  wire logic signed [15:0] req_gyro_rate,
   input  wire logic               rsp_stall,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_x_position,
   output logic signed [31:0]      rsp_y_position,
   output logic signed [31:0]      rsp_heading,
   output logic signed [31:0]      rsp_travelled
);

   logic [1:0]  method_ff;
   logic        lpol_ff, rpol_ff;
   logic [31:0] tpc_ff, iwb_ff, ggain_ff;
   logic [30:0] glim_ff;

   logic [31:0] last_left_ff, last_right_ff;
   logic [31:0] pos_x_ff, pos_y_ff, yaw_ff, total_ff;
   logic        rsp_valid_ff;

   logic signed [32:0] inc_l_ff, inc_r_ff, inc_l_in, inc_r_in;
   logic [31:0] dl, dr;
   logic signed [15:0] gyro_ff;
   logic signed [65:0] prod_l_ff, prod_r_ff;
   logic signed [48:0] gprod_ff;
   logic signed [31:0] sl_ff, sr_ff, dd_ff;
   logic signed [32:0] ssum, sdiff;
   logic signed [65:0] dprod;
   logic [31:0] dto_ff, dth_ff, dg, err, err_mag;
   logic        use_arc_ff;

   logic [31:0] ang, ang_m, ang_f;
   logic        flip;
   logic signed [33:0] cx_ff, cy_ff, cz_ff, xs, ys;
   logic [ddo_pkg::CORD_IDX_W-1:0] cord_i_ff;
   logic        flip_ff;
   logic [31:0] atan_v;
   logic signed [34:0] cos_v, sin_v;
   logic signed [34:0] c0_ff, s0_ff, c1_ff, s1_ff;

   logic signed [35:0] diff;
   logic signed [67:0] num_full;
   logic signed [63:0] num_ff;
   logic [63:0] num_mag;
   logic [31:0] den_mag;
   logic        qneg_ff;
   logic        div_done;
   logic [63:0] quo;
   logic [33:0] qclamp;
   logic signed [34:0] qs;
   logic signed [69:0] arc_prod;
   logic signed [66:0] mid_px, mid_py;
   logic [31:0] dx_ff, dy_ff;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [65:0] s;
      s = v >>> 8;
      if (s > 66'sd2147483647) return 32'sh7FFFFFFF;
      if (s < -66'sd2147483648) return 32'sh80000000;
      return s[31:0];
   endfunction

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff <= ddo_pkg::METHOD_MID;
         lpol_ff   <= 1'b0;
         rpol_ff   <= 1'b0;
         tpc_ff    <= '0;
         iwb_ff    <= '0;
         ggain_ff  <= '0;
         glim_ff   <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            ddo_pkg::CSR_METHOD:    method_ff <= csr_data[1:0];
            ddo_pkg::CSR_LEFT_POL:  lpol_ff   <= csr_data[0];
            ddo_pkg::CSR_RIGHT_POL: rpol_ff   <= csr_data[0];
            ddo_pkg::CSR_TRAVEL:    tpc_ff    <= csr_data;
            ddo_pkg::CSR_INV_BASE:  iwb_ff    <= csr_data;
            ddo_pkg::CSR_GYRO_GAIN: ggain_ff  <= csr_data;
            ddo_pkg::CSR_GYRO_LIM:  glim_ff   <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // increments and products
   always_comb begin
      dl       = 32'(req_left_count - last_left_ff);
      dr       = 32'(req_right_count - last_right_ff);
      inc_l_in = lpol_ff ? -$signed({dl[31], dl}) : $signed({dl[31], dl});
      inc_r_in = rpol_ff ? -$signed({dr[31], dr}) : $signed({dr[31], dr});
      ssum     = 33'(sl_ff) + 33'(sr_ff);
      sdiff    = 33'(sr_ff) - 33'(sl_ff);
      dprod    = sdiff * $signed({1'b0, iwb_ff});
      dg       = gprod_ff[47:16];
      err      = dg - dto_ff;
      err_mag  = err[31] ? (32'd0 - err) : err;
   end

   // cordic
   always_comb begin
      case (cmd.cord_ang)
         ddo_pkg::ANG_YAW_DTO: ang = yaw_ff + dto_ff;
         ddo_pkg::ANG_MID:     ang = yaw_ff + {dth_ff[31], dth_ff[31:1]};
         default:              ang = yaw_ff;
      endcase
      ang_m  = ang & ddo_pkg::ANGLE_MASK;
      flip   = (ang_m + 32'h4000_0000) > 32'h8000_0000;
      ang_f  = flip ? (ang_m - 32'h8000_0000) : ang_m;
      xs     = cx_ff >>> cord_i_ff;
      ys     = cy_ff >>> cord_i_ff;
      atan_v = ddo_pkg::atan_bam(5'(cord_i_ff));
      cos_v  = flip_ff ? -35'(cx_ff) : 35'(cx_ff);
      sin_v  = flip_ff ? -35'(cy_ff) : 35'(cy_ff);
   end

   // arc terms
   always_comb begin
      diff     = cmd.axis ? (36'(c0_ff) - 36'(c1_ff)) : (36'(s1_ff) - 36'(s0_ff));
      num_full = dd_ff * diff;
      num_mag  = num_ff[63] ? 64'(-num_ff) : 64'(num_ff);
      den_mag  = dth_ff[31] ? (32'd0 - dth_ff) : dth_ff;
      qclamp   = (quo > ddo_pkg::ARC_LIMIT) ? 34'(ddo_pkg::ARC_LIMIT) : quo[33:0];
      qs       = qneg_ff ? -$signed({1'b0, qclamp}) : $signed({1'b0, qclamp});
      arc_prod = qs * ddo_pkg::TWO_OVER_PI;
      mid_px   = dd_ff * cos_v;
      mid_py   = dd_ff * sin_v;
   end

   ddo_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num_mag),
      .den   (den_mag),
      .done  (div_done),
      .quo   (quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         last_left_ff  <= '0;
         last_right_ff <= '0;
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         yaw_ff        <= '0;
         total_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.load) begin
            last_left_ff  <= req_left_count;
            last_right_ff <= req_right_count;
         end
         if (cmd.update) begin
            pos_x_ff     <= pos_x_ff + dx_ff;
            pos_y_ff     <= pos_y_ff + dy_ff;
            yaw_ff       <= yaw_ff + dth_ff;
            total_ff     <= total_ff + dd_ff;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         inc_l_ff <= inc_l_in;
         inc_r_ff <= inc_r_in;
         gyro_ff  <= req_gyro_rate;
      end
      if (cmd.mul1) begin
         prod_l_ff <= inc_l_ff * $signed({1'b0, tpc_ff});
         prod_r_ff <= inc_r_ff * $signed({1'b0, tpc_ff});
         gprod_ff  <= gyro_ff * $signed({1'b0, ggain_ff});
      end
      if (cmd.mul2) begin
         sl_ff <= sat32(prod_l_ff);
         sr_ff <= sat32(prod_r_ff);
      end
      if (cmd.mul3) begin
         dd_ff  <= ssum[32:1];
         dto_ff <= dprod[39:8];
      end
      if (cmd.sel) begin
         if (method_ff >= ddo_pkg::METHOD_GYRO && err_mag > {1'b0, glim_ff})
            dth_ff <= dg;
         else
            dth_ff <= dto_ff;
         use_arc_ff <= (method_ff == ddo_pkg::METHOD_ARC) && (dto_ff != 32'd0);
      end
      if (cmd.cord_start) begin
         cx_ff     <= ddo_pkg::CORDIC_K;
         cy_ff     <= '0;
         cz_ff     <= {{2{ang_f[31]}}, ang_f};
         cord_i_ff <= '0;
         flip_ff   <= flip;
      end else if (cmd.cord_step) begin
         if (!cz_ff[33]) begin
            cx_ff <= cx_ff - ys;
            cy_ff <= cy_ff + xs;
            cz_ff <= cz_ff - $signed({2'b00, atan_v});
         end else begin
            cx_ff <= cx_ff + ys;
            cy_ff <= cy_ff - xs;
            cz_ff <= cz_ff + $signed({2'b00, atan_v});
         end
         cord_i_ff <= cord_i_ff + 1'b1;
      end
      if (cmd.save0) begin
         c0_ff <= cos_v;
         s0_ff <= sin_v;
      end
      if (cmd.save1) begin
         c1_ff <= cos_v;
         s1_ff <= sin_v;
      end
      if (cmd.num) num_ff <= num_full[63:0];
      if (cmd.div_start) qneg_ff <= num_ff[63] ^ dth_ff[31];
      if (cmd.arc_mul) begin
         if (cmd.axis) dy_ff <= arc_prod[61:30];
         else          dx_ff <= arc_prod[61:30];
      end
      if (cmd.mid_mul) begin
         dx_ff <= mid_px[61:30];
         dy_ff <= mid_py[61:30];
      end
   end

   assign sts.cord_last = (cord_i_ff == ddo_pkg::CORD_IDX_W'(ddo_pkg::CORDIC_STEPS - 1));
   assign sts.div_done  = div_done;
   assign sts.use_arc   = use_arc_ff;
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_x_position = pos_x_ff;
   assign rsp_y_position = pos_y_ff;
   assign rsp_heading    = yaw_ff;
   assign rsp_travelled  = total_ff;

endmodule
`default_nettype wire

### hdl/ddo_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ddo_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ddo_pkg::sts_type sts,
   output ddo_pkg::cmd_type      cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_MUL1   = 4'd1;
   localparam logic [3:0] ST_MUL2   = 4'd2;
   localparam logic [3:0] ST_MUL3   = 4'd3;
   localparam logic [3:0] ST_SEL    = 4'd4;
   localparam logic [3:0] ST_CSTART = 4'd5;
   localparam logic [3:0] ST_CRUN   = 4'd6;
   localparam logic [3:0] ST_CSAVE  = 4'd7;
   localparam logic [3:0] ST_MIDMUL = 4'd8;
   localparam logic [3:0] ST_NUM    = 4'd9;
   localparam logic [3:0] ST_DIVGO  = 4'd10;
   localparam logic [3:0] ST_DIV    = 4'd11;
   localparam logic [3:0] ST_ARCMUL = 4'd12;
   localparam logic [3:0] ST_UPDATE = 4'd13;

   logic [3:0] state_ff, state_in;
   logic       pass_ff, pass_in, axis_ff, axis_in;

   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      axis_in  = axis_ff;
      cmd      = '0;
      cmd.axis = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            cmd.mul3 = 1'b1;
            state_in = ST_SEL;
         end
         ST_SEL: begin
            cmd.sel  = 1'b1;
            pass_in  = 1'b0;
            state_in = ST_CSTART;
         end
         ST_CSTART: begin
            cmd.cord_start = 1'b1;
            if (!sts.use_arc)  cmd.cord_ang = ddo_pkg::ANG_MID;
            else if (pass_ff)  cmd.cord_ang = ddo_pkg::ANG_YAW_DTO;
            else               cmd.cord_ang = ddo_pkg::ANG_YAW;
            state_in = ST_CRUN;
         end
         ST_CRUN: begin
            cmd.cord_step = 1'b1;
            if (sts.cord_last) state_in = sts.use_arc ? ST_CSAVE : ST_MIDMUL;
         end
         ST_CSAVE: begin
            if (!pass_ff) begin
               cmd.save0 = 1'b1;
               pass_in   = 1'b1;
               state_in  = ST_CSTART;
            end else begin
               cmd.save1 = 1'b1;
               axis_in   = 1'b0;
               state_in  = ST_NUM;
            end
         end
         ST_MIDMUL: begin
            cmd.mid_mul = 1'b1;
            state_in    = ST_UPDATE;
         end
         ST_NUM: begin
            cmd.num  = 1'b1;
            state_in = ST_DIVGO;
         end
         ST_DIVGO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_done) state_in = ST_ARCMUL;
         end
         ST_ARCMUL: begin
            cmd.arc_mul = 1'b1;
            if (!axis_ff) begin
               axis_in  = 1'b1;
               state_in = ST_NUM;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (sts.out_free) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pass_ff  <= 1'b0;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
         axis_ff  <= axis_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   a_update_free: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> sts.out_free)
      else $error("state update while result still pending");

   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_MUL1))
      else $error("accepted transaction did not start processing");

   a_div_once: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> (state_ff == ST_DIV) && !cmd.div_start)
      else $error("divider restarted while busy");

   a_update_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> !req_stall)
      else $error("not idle after result");

endmodule
`default_nettype wire

### test/differential_drive_odometry_tb.sv
`timescale 1ns / 1ps
module differential_drive_odometry_tb;

   typedef struct packed {
      logic signed [31:0] left_count;
      logic signed [31:0] right_count;
      logic signed [15:0] gyro_rate;
   } sample_type;

   typedef struct packed {
      logic signed [31:0] x_position;
      logic signed [31:0] y_position;
      logic signed [31:0] heading;
      logic signed [31:0] travelled;
   } pose_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_left_count = '0;
   logic signed [31:0] req_right_count = '0;
   logic signed [15:0] req_gyro_rate = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_x_position, rsp_y_position, rsp_heading, rsp_travelled;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   differential_drive_odometry dut (.*);

   always #1 clock = ~clock;

   // odometry state held by the predictor
   logic [1:0]  p_method;
   logic        p_lpol, p_rpol;
   logic [31:0] p_travel, p_invbase, p_ggain, p_glimit;
   logic [31:0] p_last_l, p_last_r, p_x, p_y, p_yaw, p_dist;

   sample_type sample_queue[$];
   pose_type   pose_queue[$];
   int      errors = 0;
   bit      quiet_phase = 1'b0;   // no random idling on either side
   bit      hold_rsp = 1'b0;      // long receiver hold-off request
   int      hold_count = 0;
   int      idle_cycles = 0;

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint sext32(logic [31:0] v);
      return longint'($signed(v));
   endfunction

   // cordic rotation to Q2.30 cosine and sine
   task automatic cordic(input logic [31:0] ang, output longint c, output longint s);
      logic [31:0] a;
      longint x, y, z, t;
      bit flip;
      a = ang & ddo_pkg::ANGLE_MASK;
      x = ddo_pkg::CORDIC_K;
      y = 0;
      flip = (a + 32'h40000000) > 32'h80000000;
      if (flip) a = a - 32'h80000000;
      z = sext32(a);
      for (int i = 0; i < ddo_pkg::CORDIC_STEPS && i < 32; i++) begin
         if (z >= 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z = z - longint'(ddo_pkg::atan_bam(i[4:0]));
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z = z + longint'(ddo_pkg::atan_bam(i[4:0]));
         end
         x = t;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = x;
      s = y;
   endtask

   function automatic longint travel_of(logic [31:0] now, logic [31:0] last, logic pol);
      longint inc, v;
      inc = sext32(now - last);
      if (pol) inc = -inc;
      v = floor_shift(inc * longint'({32'd0, p_travel}), 8);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v;
   endfunction

   function automatic longint arc_step(longint dd, longint diff, longint dth);
      longint q;
      q = (dd * diff) / dth;
      if (q > longint'(ddo_pkg::ARC_LIMIT)) q = longint'(ddo_pkg::ARC_LIMIT);
      if (q < -longint'(ddo_pkg::ARC_LIMIT)) q = -longint'(ddo_pkg::ARC_LIMIT);
      return floor_shift(q * longint'(ddo_pkg::TWO_OVER_PI), 30);
   endfunction

   task automatic predict_pose(input sample_type smp);
      longint sl, sr, dd, g, c0, s0, c1, s1;
      logic [63:0] prod;
      logic [31:0] dto, dth, dg, e, mag, dir;
      pose_type p;
      g = longint'(smp.gyro_rate);
      sl = travel_of(smp.left_count, p_last_l, p_lpol);
      sr = travel_of(smp.right_count, p_last_r, p_rpol);
      dd = floor_shift(sl + sr, 1);
      prod = 64'(sr - sl) * {32'd0, p_invbase};
      dto = prod[39:8];
      dth = dto;
      p_last_l = smp.left_count;
      p_last_r = smp.right_count;
      if (p_method == ddo_pkg::METHOD_ARC && dto != 0) begin
         cordic(p_yaw, c0, s0);
         cordic(p_yaw + dto, c1, s1);
         p_x = p_x + 32'(arc_step(dd, s1 - s0, sext32(dto)));
         p_y = p_y + 32'(arc_step(dd, c0 - c1, sext32(dto)));
      end else begin
         if (p_method >= ddo_pkg::METHOD_GYRO) begin
            dg = 32'(floor_shift(g * longint'({32'd0, p_ggain}), 16));
            e = dg - dto;
            mag = e[31] ? -e : e;
            if (mag > p_glimit) dth = dg;
         end
         dir = p_yaw + 32'(floor_shift(sext32(dth), 1));
         cordic(dir, c0, s0);
         p_x = p_x + 32'(floor_shift(dd * c0, 30));
         p_y = p_y + 32'(floor_shift(dd * s0, 30));
      end
      p_yaw = p_yaw + dth;
      p_dist = p_dist + 32'(dd);
      p.x_position = p_x;
      p.y_position = p_y;
      p.heading = p_yaw;
      p.travelled = p_dist;
      pose_queue.push_back(p);
   endtask

   // driver: presents queued samples, random gaps on the sender side
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (sample_queue.size() > 0 && (quiet_phase || $urandom_range(99) >= 34)) begin
            req_valid <= 1'b1;
            req_left_count <= sample_queue[0].left_count;
            req_right_count <= sample_queue[0].right_count;
            req_gyro_rate <= sample_queue[0].gyro_rate;
            void'(sample_queue.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // prediction happens at the accepting edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         predict_pose({req_left_count, req_right_count, req_gyro_rate});
   end

   // receiver stall: random, or held for a long stretch on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_count <= 0;
      end else if (hold_rsp && hold_count < 600) begin
         rsp_stall <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         rsp_stall <= quiet_phase ? 1'b0 : ($urandom_range(99) < 34);
      end
   end

   // monitor: compare each rsp transaction with the oldest prediction
   always @(posedge clock) begin
      pose_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pose_queue.size() == 0) begin
            $error("unexpected rsp transaction");
            errors++;
         end else begin
            want = pose_queue.pop_front();
            if (rsp_x_position !== want.x_position) begin
               $error("x_position expected %h actual %h", want.x_position, rsp_x_position);
               errors++;
            end
            if (rsp_y_position !== want.y_position) begin
               $error("y_position expected %h actual %h", want.y_position, rsp_y_position);
               errors++;
            end
            if (rsp_heading !== want.heading) begin
               $error("heading expected %h actual %h", want.heading, rsp_heading);
               errors++;
            end
            if (rsp_travelled !== want.travelled) begin
               $error("travelled expected %h actual %h", want.travelled, rsp_travelled);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no accepted transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         ddo_pkg::CSR_METHOD:    p_method = val[1:0];
         ddo_pkg::CSR_LEFT_POL:  p_lpol = val[0];
         ddo_pkg::CSR_RIGHT_POL: p_rpol = val[0];
         ddo_pkg::CSR_TRAVEL:    p_travel = val;
         ddo_pkg::CSR_INV_BASE:  p_invbase = val;
         ddo_pkg::CSR_GYRO_GAIN: p_ggain = val;
         ddo_pkg::CSR_GYRO_LIM:  p_glimit = {1'b0, val[30:0]};
         default: ;
      endcase
   endtask

   // wait until every sample is accepted and every pose returned
   task automatic drain();
      while (sample_queue.size() > 0 || pose_queue.size() > 0 || req_valid)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // set up one full register setting
   task automatic configure(input logic [1:0] m, input logic lp, input logic rp,
                            input logic [31:0] tpc, input logic [31:0] iwb,
                            input logic [31:0] gg, input logic [31:0] gl);
      write_reg(ddo_pkg::CSR_METHOD, {30'd0, m});
      write_reg(ddo_pkg::CSR_LEFT_POL, {31'd0, lp});
      write_reg(ddo_pkg::CSR_RIGHT_POL, {31'd0, rp});
      write_reg(ddo_pkg::CSR_TRAVEL, tpc);
      write_reg(ddo_pkg::CSR_INV_BASE, iwb);
      write_reg(ddo_pkg::CSR_GYRO_GAIN, gg);
      write_reg(ddo_pkg::CSR_GYRO_LIM, gl);
   endtask

   // realistic motion: mostly small count steps around a running position, some random jumps
   task automatic add_motion(input int n, inout logic [31:0] lc, inout logic [31:0] rc);
      sample_type s;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(19) == 0) begin
            lc = $urandom;
            rc = $urandom;
         end else begin
            lc = lc + 32'($signed($urandom_range(800)) - 400);
            rc = rc + 32'($signed($urandom_range(800)) - 400);
         end
         s.left_count = lc;
         s.right_count = rc;
         s.gyro_rate = 16'($urandom);
         sample_queue.push_back(s);
      end
   endtask

   initial begin
      logic [31:0] lc, rc;
      sample_type s;
      p_method = ddo_pkg::METHOD_MID;
      {p_lpol, p_rpol} = '0;
      {p_travel, p_invbase, p_ggain, p_glimit} = '0;
      {p_last_l, p_last_r, p_x, p_y, p_yaw, p_dist} = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes of counts and gyro under each method
      configure(ddo_pkg::METHOD_MID, 1'b0, 1'b0, 32'h0100_0000, 32'h0028_0000,
                32'h0001_0000, 32'd1000);
      sample_queue.push_back({32'sd0, 32'sd0, 16'sd0});
      sample_queue.push_back({32'sd100, 32'sd100, 16'sd0});          // straight line
      sample_queue.push_back({32'sh7fffffff, 32'sh80000000, 16'sh7fff});
      sample_queue.push_back({32'sh80000000, 32'sh7fffffff, 16'sh8000});
      sample_queue.push_back({32'sd50, 32'sd300, -16'sd1});
      drain();
      configure(ddo_pkg::METHOD_ARC, 1'b1, 1'b0, 32'hffff_ffff, 32'hffff_ffff,
                32'hffff_ffff, 32'd0);
      sample_queue.push_back({32'sd0, 32'sd0, 16'sd0});
      sample_queue.push_back({32'sd10, 32'sd10, 16'sd5});            // equal counts, inverted left: spin in place
      sample_queue.push_back({32'sd10, 32'sd40, 16'sd5});
      sample_queue.push_back({32'sh80000000, 32'sh80000000, 16'sh8000}); // counts at -2^31, gyro at its minimum
      sample_queue.push_back({32'sd200, -32'sd300, 16'sh7fff});
      drain();
      configure(ddo_pkg::METHOD_GYRO, 1'b0, 1'b1, 32'h0000_0001, 32'h0000_0000,
                32'h7fff_ffff, 32'h7fff_ffff);
      sample_queue.push_back({32'sd5, 32'sd9, 16'sh7fff});
      sample_queue.push_back({32'sd1, 32'sd2, 16'sh8000});
      drain();
      configure(ddo_pkg::METHOD_GYRO_ALT, 1'b1, 1'b1, 32'h0080_0000, 32'h0020_0000,
                32'h0100_0000, 32'd0);
      sample_queue.push_back({32'sd0, 32'sd0, 16'sh7fff});           // unused code as gyro
      sample_queue.push_back({32'sd90, 32'sd10, -16'sd300});
      drain();

      // random phases over several settings
      lc = p_last_l;
      rc = p_last_r;
      for (int ph = 0; ph < 10; ph++) begin
         configure(2'($urandom_range(3)), 1'($urandom), 1'($urandom),
                   ph == 0 ? 32'hffff_ffff : 32'($urandom_range(32'h0200_0000)),
                   ph == 1 ? 32'hffff_ffff : 32'($urandom_range(32'h0100_0000)),
                   ph == 2 ? 32'd0 : $urandom,
                   ph == 3 ? 32'h7fff_ffff : 32'($urandom_range(32'h0200_0000)));
         quiet_phase = (ph == 4);
         add_motion(90, lc, rc);
         for (int i = 0; i < 18; i++) begin                          // noise
            s = {$urandom, $urandom, 16'($urandom)};
            sample_queue.push_back(s);
            lc = s.left_count;
            rc = s.right_count;
         end
         if (ph == 6) begin
            // receiver holds off while the sender keeps offering
            hold_rsp = 1'b1;
            while (hold_count < 600) @(posedge clock);
            hold_rsp = 1'b0;
         end
         drain();
      end
      quiet_phase = 1'b0;

      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
